>>> src/cts_pkg.sv
// Shared types, constants and helpers for the curve tracer sweep sequencer.
package cts_pkg;

   localparam int MAX_INNER_POINTS = 1024;
   localparam int MAX_CURVES = 256;

   localparam int VOLT_W = 20;
   localparam int INNER_COUNT_W = 11;
   localparam int OUTER_COUNT_W = 9;
   localparam int LIMIT_W = 36;
   localparam int LIMIT3_W = LIMIT_W + 2;
   localparam int AVOLTS_W = 19;
   localparam int ACURRENT_W = 18;
   localparam int POWER_W = AVOLTS_W + ACURRENT_W;
   localparam int PROGRESS_W = 7;

   localparam int PCT_FULL = 100;
   localparam int TOTAL_W = $clog2(MAX_INNER_POINTS * MAX_CURVES + 1);
   localparam int DIVD_W = $clog2(PCT_FULL * MAX_INNER_POINTS * MAX_CURVES + 1);
   localparam int DIVW_W = TOTAL_W + PROGRESS_W;
   localparam int PROD_W = VOLT_W + INNER_COUNT_W + 1;
   localparam int SUM_W = PROD_W + 2;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_INDEX_W = 3;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   localparam logic signed [VOLT_W-1:0] VOLT_MAX = {1'b0, {(VOLT_W-1){1'b1}}};
   localparam logic signed [VOLT_W-1:0] VOLT_MIN = {1'b1, {(VOLT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_READY  = 2'd1,
      MODE_FAILED = 2'd2,
      MODE_ABORT  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_SETPOINT  = 3'd0,
      KIND_SAMPLE    = 3'd1,
      KIND_CURVE_END = 3'd2,
      KIND_COMPLETE  = 3'd3,
      KIND_ABORTED   = 3'd4
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_INNER_START = 3'd0,
      REG_INNER_STEP  = 3'd1,
      REG_INNER_COUNT = 3'd2,
      REG_OUTER_START = 3'd3,
      REG_OUTER_STEP  = 3'd4,
      REG_OUTER_COUNT = 3'd5,
      REG_POWER_LIMIT = 3'd6,
      REG_DISCHARGE   = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SMP_MUL,
      ST_SMP_EMIT,
      ST_ADVANCE,
      ST_CEND,
      ST_OMUL,
      ST_OSAT,
      ST_SP_MUL,
      ST_SP_ADD,
      ST_SP_SCALE,
      ST_SP_DIV,
      ST_SP_EMIT,
      ST_COMPLETE,
      ST_ABORT
   } back_state_type;

   typedef struct packed {
      mode_type                mode;
      logic [AVOLTS_W-1:0]     anode_volts;
      logic [ACURRENT_W-1:0]   anode_current;
   } req_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [VOLT_W-1:0]  inner_value;
      logic signed [VOLT_W-1:0]  outer_value;
      logic                      first_of_curve;
      logic [PROGRESS_W-1:0]     progress;
      logic                      discharge;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      mode_type             mode;
      logic [POWER_W-1:0]   power;
   } cmd_type;

   typedef struct packed {
      logic signed [VOLT_W-1:0]   inner_start;
      logic signed [VOLT_W-1:0]   inner_step;
      logic [INNER_COUNT_W-1:0]   inner_count;
      logic signed [VOLT_W-1:0]   outer_start;
      logic signed [VOLT_W-1:0]   outer_step;
      logic [OUTER_COUNT_W-1:0]   outer_count;
      logic [LIMIT_W-1:0]         power_limit;
      logic [LIMIT3_W-1:0]        power_limit3;
      logic                       discharge_on_complete;
   } cfg_type;

   function automatic logic signed [VOLT_W-1:0] sat_volt(input logic signed [SUM_W-1:0] v);
      logic signed [VOLT_W-1:0] r;
      if (v > SUM_W'(VOLT_MAX)) begin
         r = VOLT_MAX;
      end else if (v < SUM_W'(VOLT_MIN)) begin
         r = VOLT_MIN;
      end else begin
         r = v[VOLT_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/cts_csr.sv
// Configuration register file behind the APB-style port.
module cts_csr
   import cts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index = reg_index_type'(csr_paddr[CSR_ADDR_W-1 -: CSR_INDEX_W]);
   assign write_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inner_start <= '0;
         cfg_ff.inner_step <= '0;
         cfg_ff.inner_count <= INNER_COUNT_W'(1);
         cfg_ff.outer_start <= '0;
         cfg_ff.outer_step <= '0;
         cfg_ff.outer_count <= OUTER_COUNT_W'(1);
         cfg_ff.power_limit <= '0;
         cfg_ff.power_limit3 <= '0;
         cfg_ff.discharge_on_complete <= 1'b0;
      end else if (write_en) begin
         case (index)
            REG_INNER_START: cfg_ff.inner_start <= csr_pwdata[VOLT_W-1:0];
            REG_INNER_STEP:  cfg_ff.inner_step <= csr_pwdata[VOLT_W-1:0];
            REG_INNER_COUNT: cfg_ff.inner_count <= csr_pwdata[INNER_COUNT_W-1:0];
            REG_OUTER_START: cfg_ff.outer_start <= csr_pwdata[VOLT_W-1:0];
            REG_OUTER_STEP:  cfg_ff.outer_step <= csr_pwdata[VOLT_W-1:0];
            REG_OUTER_COUNT: cfg_ff.outer_count <= csr_pwdata[OUTER_COUNT_W-1:0];
            REG_POWER_LIMIT: begin
               cfg_ff.power_limit <= csr_pwdata[LIMIT_W-1:0];
               cfg_ff.power_limit3 <= LIMIT3_W'(csr_pwdata[LIMIT_W-1:0])
                                    + {csr_pwdata[LIMIT_W-1:0], 1'b0};
            end
            REG_DISCHARGE:   cfg_ff.discharge_on_complete <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_INNER_START: csr_prdata = CSR_DATA_W'(cfg_ff.inner_start);
         REG_INNER_STEP:  csr_prdata = CSR_DATA_W'(cfg_ff.inner_step);
         REG_INNER_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.inner_count);
         REG_OUTER_START: csr_prdata = CSR_DATA_W'(cfg_ff.outer_start);
         REG_OUTER_STEP:  csr_prdata = CSR_DATA_W'(cfg_ff.outer_step);
         REG_OUTER_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.outer_count);
         REG_POWER_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.power_limit);
         REG_DISCHARGE:   csr_prdata = CSR_DATA_W'(cfg_ff.discharge_on_complete);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

>>> src/cts_front.sv
// Input stage: take an event item, form its anode power and pass it on as a command.
module cts_front
   import cts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   output logic      req_full,
   input  req_type   req_data,
   output logic      cmd_push,
   input  logic      cmd_full,
   output cmd_type   cmd_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type hold_ff;
   logic    accept;

   assign req_full = valid_ff & cmd_full;
   assign accept = req_push & ~req_full;
   assign cmd_push = valid_ff & ~cmd_full;
   assign valid_in = accept | (valid_ff & cmd_full);

   always_comb begin
      cmd_data.mode = hold_ff.mode;
      cmd_data.power = POWER_W'(hold_ff.anode_volts) * POWER_W'(hold_ff.anode_current);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= req_data;
      end
   end

endmodule

>>> src/cts_cmd_queue.sv
// Short command queue between the input stage and the sweep engine.
module cts_cmd_queue
   import cts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   output logic      full,
   input  cmd_type   push_data,
   input  logic      pop,
   output logic      valid,
   output cmd_type   pop_data
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            mem_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full = (count_ff == CNT_W'(CMD_DEPTH));
   assign valid = (count_ff != '0);
   assign do_push = push & ~full;
   assign do_pop = pop & valid;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/cts_back.sv
// Sweep engine: run the two-level sweep, work out progress and queue the result items.
module cts_back
   import cts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      cmd_valid,
   input  cmd_type   cmd_data,
   output logic      cmd_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_data
);

   localparam int RPTR_W = $clog2(RSP_DEPTH);
   localparam int RCNT_W = $clog2(RSP_DEPTH + 1);
   localparam int BIT_W = $clog2(PROGRESS_W);

   back_state_type state_ff, state_in;

   cmd_type                    cmd_ff;
   logic                       overload_ff;
   logic                       running_ff;
   logic [INNER_COUNT_W-1:0]   inner_index_ff;
   logic [OUTER_COUNT_W-1:0]   outer_index_ff;
   logic signed [VOLT_W-1:0]   outer_voltage_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [TOTAL_W-1:0]         done_ff;
   logic [TOTAL_W-1:0]         total_ff;
   logic [DIVD_W-1:0]          rem_ff;
   logic [PROGRESS_W-1:0]      quo_ff;
   logic [BIT_W-1:0]           bit_ff;

   logic [INNER_COUNT_W-1:0]   eff_inner;
   logic [OUTER_COUNT_W-1:0]   eff_outer;
   logic [INNER_COUNT_W:0]     inner_next;
   logic [OUTER_COUNT_W:0]     outer_next;
   logic                       inner_more;
   logic                       outer_more;
   logic signed [VOLT_W-1:0]   inner_volts;
   logic [DIVW_W-1:0]          trial;
   logic                       trial_fits;

   rsp_type                    rq_mem_ff [RSP_DEPTH];
   logic [RPTR_W-1:0]          rq_wr_ff;
   logic [RPTR_W-1:0]          rq_rd_ff;
   logic [RCNT_W-1:0]          rq_count_ff;
   logic                       rq_full;
   logic                       rq_push;
   logic                       rq_pop;
   rsp_type                    rq_item;

   always_comb begin
      if (cfg.inner_count == '0) begin
         eff_inner = INNER_COUNT_W'(1);
      end else if (cfg.inner_count > INNER_COUNT_W'(MAX_INNER_POINTS)) begin
         eff_inner = INNER_COUNT_W'(MAX_INNER_POINTS);
      end else begin
         eff_inner = cfg.inner_count;
      end
      if (cfg.outer_count == '0) begin
         eff_outer = OUTER_COUNT_W'(1);
      end else if (cfg.outer_count > OUTER_COUNT_W'(MAX_CURVES)) begin
         eff_outer = OUTER_COUNT_W'(MAX_CURVES);
      end else begin
         eff_outer = cfg.outer_count;
      end
   end

   assign inner_next = {1'b0, inner_index_ff} + 1'b1;
   assign outer_next = {1'b0, outer_index_ff} + 1'b1;
   assign inner_more = inner_next < {1'b0, eff_inner};
   assign outer_more = outer_next < {1'b0, eff_outer};
   assign inner_volts = sat_volt(SUM_W'(cfg.inner_start) + SUM_W'(prod_ff));
   assign trial = DIVW_W'(total_ff) << bit_ff;
   assign trial_fits = DIVW_W'(rem_ff) >= trial;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff.mode)
               MODE_START:  state_in = running_ff ? ST_IDLE : ST_OSAT;
               MODE_READY:  state_in = running_ff ? ST_SMP_MUL : ST_IDLE;
               MODE_FAILED: state_in = running_ff ? ST_ADVANCE : ST_IDLE;
               MODE_ABORT:  state_in = running_ff ? ST_ABORT : ST_IDLE;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_SMP_MUL: state_in = ST_SMP_EMIT;
         ST_SMP_EMIT: begin
            if (!rq_full) begin
               state_in = overload_ff ? ST_CEND : ST_ADVANCE;
            end
         end
         ST_ADVANCE: state_in = inner_more ? ST_SP_MUL : ST_CEND;
         ST_CEND: begin
            if (!rq_full) begin
               state_in = outer_more ? ST_OMUL : ST_COMPLETE;
            end
         end
         ST_OMUL:     state_in = ST_OSAT;
         ST_OSAT:     state_in = ST_SP_MUL;
         ST_SP_MUL:   state_in = ST_SP_ADD;
         ST_SP_ADD:   state_in = ST_SP_SCALE;
         ST_SP_SCALE: state_in = ST_SP_DIV;
         ST_SP_DIV: begin
            if (bit_ff == '0) begin
               state_in = ST_SP_EMIT;
            end
         end
         ST_SP_EMIT, ST_COMPLETE, ST_ABORT: begin
            if (!rq_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop = 1'b0;
      rq_push = 1'b0;
      rq_item = '0;
      case (state_ff)
         ST_IDLE: cmd_pop = cmd_valid;
         ST_SMP_EMIT: begin
            rq_push = ~rq_full;
            rq_item.kind = KIND_SAMPLE;
            rq_item.inner_value = inner_volts;
            rq_item.outer_value = outer_voltage_ff;
         end
         ST_CEND: begin
            rq_push = ~rq_full;
            rq_item.kind = KIND_CURVE_END;
            rq_item.outer_value = outer_voltage_ff;
         end
         ST_SP_EMIT: begin
            rq_push = ~rq_full;
            rq_item.kind = KIND_SETPOINT;
            rq_item.inner_value = inner_volts;
            rq_item.outer_value = outer_voltage_ff;
            rq_item.first_of_curve = (inner_index_ff == '0);
            rq_item.progress = (quo_ff > PROGRESS_W'(PCT_FULL)) ? PROGRESS_W'(PCT_FULL) : quo_ff;
            rq_item.last = 1'b1;
         end
         ST_COMPLETE: begin
            rq_push = ~rq_full;
            rq_item.kind = KIND_COMPLETE;
            rq_item.outer_value = outer_voltage_ff;
            rq_item.progress = PROGRESS_W'(PCT_FULL);
            rq_item.discharge = cfg.discharge_on_complete;
            rq_item.last = 1'b1;
         end
         ST_ABORT: begin
            rq_push = ~rq_full;
            rq_item.kind = KIND_ABORTED;
            rq_item.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         running_ff <= 1'b0;
         inner_index_ff <= '0;
         outer_index_ff <= '0;
         outer_voltage_ff <= '0;
         bit_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_DECODE: begin
               if (cmd_ff.mode == MODE_START && !running_ff) begin
                  running_ff <= 1'b1;
                  inner_index_ff <= '0;
                  outer_index_ff <= '0;
               end
               if (cmd_ff.mode == MODE_ABORT) begin
                  running_ff <= 1'b0;
               end
            end
            ST_ADVANCE: inner_index_ff <= inner_next[INNER_COUNT_W-1:0];
            ST_CEND: begin
               if (!rq_full) begin
                  outer_index_ff <= outer_next[OUTER_COUNT_W-1:0];
                  if (outer_more) begin
                     inner_index_ff <= '0;
                  end else begin
                     running_ff <= 1'b0;
                  end
               end
            end
            ST_OSAT: outer_voltage_ff <= sat_volt(SUM_W'(cfg.outer_start) + SUM_W'(prod_ff));
            ST_SP_SCALE: bit_ff <= BIT_W'(PROGRESS_W - 1);
            ST_SP_DIV: bit_ff <= bit_ff - 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_ff <= cmd_data;
            end
         end
         ST_DECODE: begin
            overload_ff <= (cfg.power_limit != '0)
                        && ((POWER_W + 1)'(cmd_ff.power) > cfg.power_limit3);
            prod_ff <= '0;
         end
         ST_SMP_MUL, ST_SP_MUL: begin
            prod_ff <= PROD_W'($signed({1'b0, inner_index_ff})) * PROD_W'(cfg.inner_step);
         end
         ST_OMUL: begin
            prod_ff <= PROD_W'($signed({1'b0, outer_index_ff})) * PROD_W'(cfg.outer_step);
         end
         default: ;
      endcase
      case (state_ff)
         ST_SP_MUL: begin
            done_ff <= TOTAL_W'(outer_index_ff) * TOTAL_W'(eff_inner);
            total_ff <= TOTAL_W'(eff_outer) * TOTAL_W'(eff_inner);
         end
         ST_SP_ADD: done_ff <= done_ff + TOTAL_W'(inner_index_ff);
         ST_SP_SCALE: begin
            rem_ff <= DIVD_W'(done_ff) * DIVD_W'(PCT_FULL);
            quo_ff <= '0;
         end
         ST_SP_DIV: begin
            if (trial_fits) begin
               rem_ff <= DIVD_W'(DIVW_W'(rem_ff) - trial);
               quo_ff[bit_ff] <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result queue
   assign rq_full = (rq_count_ff == RCNT_W'(RSP_DEPTH));
   assign rsp_empty = (rq_count_ff == '0);
   assign rq_pop = rsp_pop & ~rsp_empty;
   assign rsp_data = rq_mem_ff[rq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff <= '0;
         rq_rd_ff <= '0;
         rq_count_ff <= '0;
      end else begin
         if (rq_push) begin
            rq_wr_ff <= (rq_wr_ff == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rq_wr_ff + 1'b1;
         end
         if (rq_pop) begin
            rq_rd_ff <= (rq_rd_ff == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rq_rd_ff + 1'b1;
         end
         rq_count_ff <= rq_count_ff + RCNT_W'(rq_push) - RCNT_W'(rq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_mem_ff[rq_wr_ff] <= rq_item;
      end
   end

endmodule

>>> src/curve_tracer_sweep_sequencer.sv
// Top level of the curve tracer sweep sequencer.
//
//   channel   ports              direction   handshake
//   event     req_*              in          push / full
//   result    rsp_*              out         empty / pop
//   config    csr_*              in/out      APB-style, 64-bit data, 8-byte stride
//
// In the sweep engine every event is decoded first; a setpoint then passes through the multiply,
// add, scale, progress divider and emit states, and events that do nothing go back to idle.
// Up to two events wait in the command queue and four result items in the result queue.
// Reset is synchronous and active high; it clears the sweep state and all queues.
// A full result queue stalls the engine; a stalled engine raises req_full once the
// command queue is full and the input stage holds an event.
module curve_tracer_sweep_sequencer
   import cts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  req_type                 req_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output rsp_type                 rsp_data,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   cfg_type cfg;
   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_valid;
   logic    cmd_pop;

   cts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (front_cmd)
   );

   cts_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .full      (cmd_full),
      .push_data (front_cmd),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .pop_data  (queue_cmd)
   );

   cts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_data  (queue_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/cts_checker.sv
// Port-level checks for the curve tracer sweep sequencer, bound to the top level.
module cts_checker
   import cts_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_full,
   input logic      rsp_empty,
   input logic      rsp_pop,
   input rsp_type   rsp_data,
   input logic      csr_pready
);

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready low");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result item changed");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.progress <= PROGRESS_W'(PCT_FULL))
      else $error("progress above full scale");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.last ==
         !(rsp_data.kind == KIND_SAMPLE || rsp_data.kind == KIND_CURVE_END))
      else $error("last mark wrong for result kind");

endmodule

bind curve_tracer_sweep_sequencer cts_checker u_checker (.*);
